[hdl/crs_pkg.sv]
package crs_pkg;

  // Block limits
  localparam int MAX_DATA_CHUNKS   = 32;
  localparam int MAX_PARITY_CHUNKS = 16;
  localparam int MAX_CHUNK_LEN     = 256;

  // Field and counter widths
  localparam int K_W    = 6;
  localparam int R_W    = 5;
  localparam int LEN_W  = 9;
  localparam int J_W    = $clog2(MAX_DATA_CHUNKS);
  localparam int ROW_W  = $clog2(MAX_PARITY_CHUNKS);
  localparam int COL_W  = $clog2(MAX_CHUNK_LEN);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int BASE_W = J_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CHUNKS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_CHUNKS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN     = CFG_IDX_W'(2);

  // Reset values of the registers
  localparam logic [K_W-1:0]   K_RST   = K_W'(4);
  localparam logic [R_W-1:0]   R_RST   = R_W'(2);
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(64);

  // GF(256) field
  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef logic [255:0][7:0] gf_tbl_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              rd;
    logic [ROW_W-1:0]  row_a;
    logic [BASE_W-1:0] base;
    logic [COL_W-1:0]  col;
    logic              wr;
    logic [ROW_W-1:0]  row_b;
    logic              first;
    logic              emit;
    logic              last_run;
    logic              blk_done;
    logic              err;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

  // Antilog table: alpha^n, entry 255 wraps to 1
  function automatic gf_tbl_t gf_exp_table();
    gf_tbl_t    t;
    logic [8:0] x;
    t = '0;
    x = 9'd1;
    for (int n = 0; n < 255; n++) begin
      t[n] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    t[255] = 8'd1;
    return t;
  endfunction

  // Log table: inverse of the antilog table, log of zero unused
  function automatic gf_tbl_t gf_log_table();
    gf_tbl_t    t;
    logic [8:0] x;
    t = '0;
    x = 9'd1;
    for (int n = 0; n < 255; n++) begin
      t[x[7:0]] = 8'(n);
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

endpackage

[hdl/cauchy_rs_erasure_encoder_core.sv]
// Channel  Handshake               Payload
// in       in_valid / in_stall     in_data_byte
// out      out_valid / out_stall   parity_byte, parity_row, byte_offset,
//                                  last_of_run, block_done, status
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A data byte is taken in IDLE, then each parity row passes through the
// read / write-back pipeline on the parity store until it drains. A bad
// configuration instead goes to an error state that emits a status result.
// Reset (rst_n, synchronous) loads k = 4, r = 2, chunk length 64 and clears
// the chunk and byte counters; the parity store needs no clearing. cfg_ready
// is always high. A stalled output freezes the row pipeline on the last chunk.
module cauchy_rs_erasure_encoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_parity_byte,
  output logic [crs_pkg::ROW_W-1:0]         out_parity_row,
  output logic [crs_pkg::COL_W-1:0]         out_byte_offset,
  output logic                              out_last_of_run,
  output logic                              out_block_done,
  output logic                              out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [crs_pkg::K_W-1:0]   k_r;
  logic [crs_pkg::R_W-1:0]   r_r;
  logic [crs_pkg::LEN_W-1:0] len_r;
  logic                      restart;
  crs_pkg::cmd_t             cmd;
  crs_pkg::sts_t             sts;

  assign cfg_ready = 1'b1;

  // Configuration registers; a listed write restarts the block
  always_comb begin
    restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        crs_pkg::REG_DATA_CHUNKS:   restart = 1'b1;
        crs_pkg::REG_PARITY_CHUNKS: restart = 1'b1;
        crs_pkg::REG_CHUNK_LEN:     restart = 1'b1;
        default:                    restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= crs_pkg::K_RST;
      r_r   <= crs_pkg::R_RST;
      len_r <= crs_pkg::LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        crs_pkg::REG_DATA_CHUNKS:   k_r   <= cfg_data[crs_pkg::K_W-1:0];
        crs_pkg::REG_PARITY_CHUNKS: r_r   <= cfg_data[crs_pkg::R_W-1:0];
        crs_pkg::REG_CHUNK_LEN:     len_r <= cfg_data[crs_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .k_i      (k_r),
    .r_i      (r_r),
    .len_i    (len_r),
    .sts      (sts),
    .cmd      (cmd)
  );

  crs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_parity_row  (out_parity_row),
    .out_byte_offset (out_byte_offset),
    .out_last_of_run (out_last_of_run),
    .out_block_done  (out_block_done),
    .out_status      (out_status)
  );

endmodule

[hdl/crs_ctrl.sv]
module crs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        restart,
  input  logic [crs_pkg::K_W-1:0]     k_i,
  input  logic [crs_pkg::R_W-1:0]     r_i,
  input  logic [crs_pkg::LEN_W-1:0]   len_i,
  input  crs_pkg::sts_t               sts,
  output crs_pkg::cmd_t               cmd
);

  typedef enum logic [1:0] {IDLE, RUN, ERR} state_t;

  state_t                         state_r, state_nxt;
  logic [crs_pkg::J_W-1:0]        chunk_r, chunk_nxt;
  logic [crs_pkg::COL_W-1:0]      byte_r, byte_nxt;
  logic [crs_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [crs_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic                           first_r, first_nxt;
  logic                           lastc_r, lastc_nxt;
  logic                           endcol_r, endcol_nxt;
  logic [crs_pkg::ROW_W-1:0]      ra_r, ra_nxt;
  logic [crs_pkg::ROW_W-1:0]      rb_r, rb_nxt;
  logic                           a_live_r, a_live_nxt;
  logic                           b_valid_r, b_valid_nxt;

  logic                           bad;
  logic                           stale;
  logic [crs_pkg::J_W-1:0]        j_eff;
  logic [crs_pkg::COL_W-1:0]      b_eff;
  logic [crs_pkg::LEN_W-1:0]      b_inc;
  logic [crs_pkg::K_W-1:0]        j_inc;
  logic                           adv;
  logic                           last_row;

  // Configuration check
  always_comb begin
    bad = (k_i == '0) || (k_i > crs_pkg::K_W'(crs_pkg::MAX_DATA_CHUNKS)) ||
          (r_i == '0) || (r_i > crs_pkg::R_W'(crs_pkg::MAX_PARITY_CHUNKS)) ||
          ((10'(k_i) + 10'(r_i)) > 10'd255) ||
          (len_i == '0) || (len_i > crs_pkg::LEN_W'(crs_pkg::MAX_CHUNK_LEN));
  end

  // Position of the incoming byte and of the one after it
  always_comb begin
    stale = ({1'b0, chunk_r} >= k_i) || ({1'b0, byte_r} >= len_i);
    j_eff = stale ? '0 : chunk_r;
    b_eff = stale ? '0 : byte_r;
    b_inc = {1'b0, b_eff} + crs_pkg::LEN_W'(1);
    j_inc = {1'b0, j_eff} + crs_pkg::K_W'(1);
  end

  // Row pipeline: stage A reads, stage B writes back and, on the last chunk, emits
  assign adv      = !(b_valid_r && lastc_r && !sts.out_free);
  assign last_row = ({1'b0, rb_r} == (r_i - crs_pkg::R_W'(1)));
  assign in_stall = (state_r != IDLE);

  always_comb begin
    state_nxt   = state_r;
    chunk_nxt   = chunk_r;
    byte_nxt    = byte_r;
    col_nxt     = col_r;
    base_nxt    = base_r;
    first_nxt   = first_r;
    lastc_nxt   = lastc_r;
    endcol_nxt  = endcol_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    a_live_nxt  = a_live_r;
    b_valid_nxt = b_valid_r;
    cmd         = '0;
    cmd.row_a   = ra_r;
    cmd.base    = base_r;
    cmd.col     = col_r;
    cmd.row_b   = rb_r;
    cmd.first   = first_r;
    cmd.last_run = last_row;
    cmd.blk_done = last_row && endcol_r;

    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (bad) begin
            chunk_nxt = '0;
            byte_nxt  = '0;
            state_nxt = ERR;
          end else begin
            col_nxt     = b_eff;
            base_nxt    = crs_pkg::BASE_W'(r_i) + crs_pkg::BASE_W'(j_eff);
            first_nxt   = (j_eff == '0);
            lastc_nxt   = ({1'b0, j_eff} == (k_i - crs_pkg::K_W'(1)));
            endcol_nxt  = ({1'b0, b_eff} == (len_i - crs_pkg::LEN_W'(1)));
            ra_nxt      = '0;
            a_live_nxt  = 1'b1;
            b_valid_nxt = 1'b0;
            state_nxt   = RUN;
            if (b_inc >= len_i) begin
              byte_nxt  = '0;
              chunk_nxt = (j_inc >= k_i) ? '0 : j_inc[crs_pkg::J_W-1:0];
            end else begin
              byte_nxt  = b_inc[crs_pkg::COL_W-1:0];
              chunk_nxt = j_eff;
            end
          end
        end
      end
      RUN: begin
        cmd.rd   = a_live_r && adv;
        cmd.wr   = b_valid_r && adv;
        cmd.emit = b_valid_r && lastc_r && adv;
        if (adv) begin
          b_valid_nxt = a_live_r;
          rb_nxt      = ra_r;
          if (a_live_r) begin
            ra_nxt     = ra_r + crs_pkg::ROW_W'(1);
            a_live_nxt = ({1'b0, ra_r} != (r_i - crs_pkg::R_W'(1)));
          end
          if (b_valid_r && !a_live_r) begin
            state_nxt = IDLE;
          end
        end
      end
      ERR: begin
        cmd.err = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase

    // Register write restarts the block
    if (restart) begin
      chunk_nxt = '0;
      byte_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      chunk_r   <= '0;
      byte_r    <= '0;
      a_live_r  <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chunk_r   <= chunk_nxt;
      byte_r    <= byte_nxt;
      a_live_r  <= a_live_nxt;
      b_valid_r <= b_valid_nxt;
    end
    col_r    <= col_nxt;
    base_r   <= base_nxt;
    first_r  <= first_nxt;
    lastc_r  <= lastc_nxt;
    endcol_r <= endcol_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
  end

  // Pipeline is empty outside of a run
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != RUN) |-> (!a_live_r && !b_valid_r))
    else $error("row pipeline busy outside a run");

  // A result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded into a full output register");

  // A parity result always goes with its store write-back
  a_emit_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !cmd.err) |-> cmd.wr)
    else $error("parity emitted without write-back");

  // A run always starts with the first row in stage A
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE && in_valid && !bad) |=> (a_live_r && ra_r == '0 && !b_valid_r))
    else $error("run started at the wrong row");

endmodule

[hdl/crs_datapath.sv]
module crs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    in_data_byte,
  input  crs_pkg::cmd_t                 cmd,
  output crs_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_parity_byte,
  output logic [crs_pkg::ROW_W-1:0]     out_parity_row,
  output logic [crs_pkg::COL_W-1:0]     out_byte_offset,
  output logic                          out_last_of_run,
  output logic                          out_block_done,
  output logic                          out_status
);

  localparam crs_pkg::gf_tbl_t EXP_TBL = crs_pkg::gf_exp_table();
  localparam crs_pkg::gf_tbl_t LOG_TBL = crs_pkg::gf_log_table();

  // Parity store, one row per parity chunk
  logic [7:0] mem [2**crs_pkg::ADDR_W];

  logic [7:0]                  log_d_r;
  logic                        dz_r;
  logic [7:0]                  rdata_r;
  logic [7:0]                  e_r, e_nxt;
  logic [crs_pkg::BASE_W-1:0]  x;
  logic [7:0]                  log_x;
  logic [8:0]                  sum;
  logic [7:0]                  prod;
  logic [7:0]                  p;

  logic                        out_valid_r;
  logic [7:0]                  byte_r;
  logic [crs_pkg::ROW_W-1:0]   row_r;
  logic [crs_pkg::COL_W-1:0]   off_r;
  logic                        last_r;
  logic                        done_r;
  logic                        status_r;

  // Log of the data byte, taken once per request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      log_d_r <= LOG_TBL[in_data_byte];
      dz_r    <= (in_data_byte == 8'd0);
    end
  end

  // Stage A: exponent of d / (row xor (r + j)), mod 255
  always_comb begin
    x     = crs_pkg::BASE_W'(cmd.row_a) ^ cmd.base;
    log_x = LOG_TBL[8'(x)];
    sum   = {1'b0, log_d_r} + (crs_pkg::GF_ORDER - {1'b0, log_x});
    if (sum >= crs_pkg::GF_ORDER) begin
      sum = sum - crs_pkg::GF_ORDER;
    end
    e_nxt = sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      e_r     <= e_nxt;
      rdata_r <= mem[{cmd.row_a, cmd.col}];
    end
  end

  // Stage B: product, accumulate, write back
  assign prod = dz_r ? 8'd0 : EXP_TBL[e_r];
  assign p    = prod ^ (cmd.first ? 8'd0 : rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{cmd.row_b, cmd.col}] <= p;
    end
  end

  // Output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      if (cmd.err) begin
        byte_r   <= '0;
        row_r    <= '0;
        off_r    <= '0;
        last_r   <= 1'b0;
        done_r   <= 1'b0;
        status_r <= 1'b1;
      end else begin
        byte_r   <= p;
        row_r    <= cmd.row_b;
        off_r    <= cmd.col;
        last_r   <= cmd.last_run;
        done_r   <= cmd.blk_done;
        status_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_parity_byte = byte_r;
  assign out_parity_row  = row_r;
  assign out_byte_offset = off_r;
  assign out_last_of_run = last_r;
  assign out_block_done  = done_r;
  assign out_status      = status_r;

endmodule

[tb/sv/tb_cauchy_rs_erasure_encoder_core.sv]
module tb_cauchy_rs_erasure_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_TARGET    = 345;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX     = 10;

  // indexes outside the register list, writes there must be ignored
  localparam logic [crs_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = crs_pkg::CFG_IDX_W'(3);
  localparam logic [crs_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = crs_pkg::CFG_IDX_W'(15);

  typedef struct packed {
    logic [7:0]                pbyte;
    logic [crs_pkg::ROW_W-1:0] row;
    logic [crs_pkg::COL_W-1:0] offset;
    logic                      last;
    logic                      done;
    logic                      status;
  } parity_res_t;

  // Parity predictor plus queue of parity bytes still owed by the block
  class parity_ledger;
    logic [crs_pkg::K_W-1:0]   k_chunks;
    logic [crs_pkg::R_W-1:0]   r_rows;
    logic [crs_pkg::LEN_W-1:0] seg_len;
    int               chunk_at;
    int               offset_at;
    logic [7:0]       store [crs_pkg::MAX_PARITY_CHUNKS*crs_pkg::MAX_CHUNK_LEN];
    logic [7:0]       inverse [256];
    parity_res_t      due [$];
    int               errors;
    int               checked;
    int               bytes_seen;

    function new();
      k_chunks  = crs_pkg::K_RST;
      r_rows    = crs_pkg::R_RST;
      seg_len   = crs_pkg::LEN_RST;
      chunk_at  = 0;
      offset_at = 0;
      errors    = 0;
      checked   = 0;
      bytes_seen = 0;
      // inverse by search, zero maps to zero
      inverse[0] = 8'd0;
      for (int a = 1; a < 256; a++) begin
        for (int v = 1; v < 256; v++) begin
          if (gf_mul(8'(a), 8'(v)) == 8'd1) begin
            inverse[a] = 8'(v);
          end
        end
      end
    endfunction

    // shift-and-add multiply, reduced by the field polynomial
    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = 8'd0;
      for (int n = 0; n < 8; n++) begin
        if (b[n]) begin
          acc ^= x[7:0];
        end
        x = {x[7:0], 1'b0};
        if (x[8]) begin
          x ^= crs_pkg::GF_POLY;
        end
      end
      return acc;
    endfunction

    function bit layout_bad();
      if (k_chunks == 0 || int'(k_chunks) > crs_pkg::MAX_DATA_CHUNKS) return 1'b1;
      if (r_rows == 0 || int'(r_rows) > crs_pkg::MAX_PARITY_CHUNKS) return 1'b1;
      if (int'(k_chunks) + int'(r_rows) > 255) return 1'b1;
      if (seg_len == 0 || int'(seg_len) > crs_pkg::MAX_CHUNK_LEN) return 1'b1;
      return 1'b0;
    endfunction

    // register write: listed registers restart the block
    function void load_reg(logic [crs_pkg::CFG_IDX_W-1:0] idx,
                           logic [crs_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        crs_pkg::REG_DATA_CHUNKS:   k_chunks = val[crs_pkg::K_W-1:0];
        crs_pkg::REG_PARITY_CHUNKS: r_rows = val[crs_pkg::R_W-1:0];
        crs_pkg::REG_CHUNK_LEN:     seg_len = val[crs_pkg::LEN_W-1:0];
        default:                    return;
      endcase
      chunk_at  = 0;
      offset_at = 0;
    endfunction

    // accepted data byte: fold into the store, queue finished parity
    function void take_byte(logic [7:0] d);
      parity_res_t e;
      logic [7:0]  coef;
      logic [7:0]  p;
      int          addr;
      bytes_seen++;
      if (layout_bad()) begin
        e = '0;
        e.status = 1'b1;
        due.push_back(e);
        chunk_at  = 0;
        offset_at = 0;
        return;
      end
      if (chunk_at >= int'(k_chunks) || offset_at >= int'(seg_len)) begin
        chunk_at  = 0;
        offset_at = 0;
      end
      for (int i = 0; i < int'(r_rows); i++) begin
        coef = inverse[8'(i ^ (int'(r_rows) + chunk_at))];
        addr = i * crs_pkg::MAX_CHUNK_LEN + offset_at;
        p    = gf_mul(coef, d);
        if (chunk_at != 0) begin
          p ^= store[addr];
        end
        store[addr] = p;
        if (chunk_at == int'(k_chunks) - 1) begin
          e.pbyte  = p;
          e.row    = crs_pkg::ROW_W'(i);
          e.offset = crs_pkg::COL_W'(offset_at);
          e.last   = (i == int'(r_rows) - 1);
          e.done   = e.last && (offset_at == int'(seg_len) - 1);
          e.status = 1'b0;
          due.push_back(e);
        end
      end
      offset_at++;
      if (offset_at >= int'(seg_len)) begin
        offset_at = 0;
        chunk_at++;
        if (chunk_at >= int'(k_chunks)) begin
          chunk_at = 0;
        end
      end
    endfunction

    // accepted parity result against the oldest one owed
    function void match_parity(parity_res_t got);
      parity_res_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected parity result: byte %02h row %0d off %0d last %0b done %0b st %0b",
                   got.pbyte, got.row, got.offset, got.last, got.done, got.status);
        end
        return;
      end
      want = due.pop_front();
      checked++;
      if (got.pbyte !== want.pbyte || got.row !== want.row || got.offset !== want.offset ||
          got.last !== want.last || got.done !== want.done || got.status !== want.status) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("parity mismatch exp: byte %02h row %0d off %0d last %0b done %0b st %0b",
                   want.pbyte, want.row, want.offset, want.last, want.done, want.status);
          $display("                got: byte %02h row %0d off %0d last %0b done %0b st %0b",
                   got.pbyte, got.row, got.offset, got.last, got.done, got.status);
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void close_out();
      if (due.size() != 0) begin
        errors += due.size();
        $display("%0d parity results never arrived", due.size());
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_data_byte = 8'd0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_parity_byte;
  logic [crs_pkg::ROW_W-1:0]      out_parity_row;
  logic [crs_pkg::COL_W-1:0]      out_byte_offset;
  logic                           out_last_of_run;
  logic                           out_block_done;
  logic                           out_status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  parity_ledger ledger = new();
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           rand_bytes = 0;
  int           reg_writes = 0;
  int           bad_layouts = 0;

  cauchy_rs_erasure_encoder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_parity_row  (out_parity_row),
    .out_byte_offset (out_byte_offset),
    .out_last_of_run (out_last_of_run),
    .out_block_done  (out_block_done),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // result side: check accepted parity, then pick next stall
  always @(posedge clk) begin : parity_rx
    parity_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pbyte  = out_parity_byte;
      got.row    = out_parity_row;
      got.offset = out_byte_offset;
      got.last   = out_last_of_run;
      got.done   = out_block_done;
      got.status = out_status;
      ledger.match_parity(got);
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 38);
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", quiet_cycles);
      $display("tb_cauchy_rs_erasure_encoder_core: errors");
      $finish;
    end
  end

  function automatic int idle_gap();
    int g;
    g = 0;
    if (no_idle) return 0;
    while ($urandom_range(99) < 38) g++;
    return g;
  endfunction

  // one data byte request, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] d);
    int gap;
    gap = idle_gap();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.take_byte(d);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_byte(8'($urandom));
      rand_bytes++;
    end
  endtask

  // wait until all parity is in and the row pipeline has drained
  task automatic quiesce();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [crs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [crs_pkg::CFG_DATA_W-1:0] val);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.load_reg(idx, val);
    reg_writes++;
  endtask

  // all three registers in random order, junk in the unused upper bits
  task automatic set_layout(input int k, input int r, input int len);
    int first;
    first = $urandom_range(2);
    for (int n = 0; n < 3; n++) begin
      case ((first + n) % 3)
        0:       write_reg(crs_pkg::REG_DATA_CHUNKS, {10'($urandom), 6'(k)});
        1:       write_reg(crs_pkg::REG_PARITY_CHUNKS, {11'($urandom), 5'(r)});
        default: write_reg(crs_pkg::REG_CHUNK_LEN, {7'($urandom), 9'(len)});
      endcase
    end
  endtask

  initial begin : stim
    int k;
    int r;
    int len;
    int total;
    int cut;
    int bad_val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset k = 4, r = 2; one byte per chunk
    write_reg(crs_pkg::REG_CHUNK_LEN, crs_pkg::CFG_DATA_W'(1));
    send_byte(8'h00);
    send_byte(8'hFF);
    // unlisted index mid-block: no restart
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    send_byte(8'h01);
    send_byte(8'h80);
    // listed register rewritten mid-block: restart
    send_byte(8'h7F);
    write_reg(REG_UNUSED_HI, 16'h0000);
    write_reg(crs_pkg::REG_PARITY_CHUNKS, crs_pkg::CFG_DATA_W'(2));
    repeat (4) send_byte(8'hFF);

    // all sixteen parity rows, zero data included
    set_layout(1, 16, 1);
    send_byte(8'hFF);
    send_byte(8'h00);

    // each bad layout in turn, then a good block after the last one
    set_layout(2, 2, 1);
    write_reg(crs_pkg::REG_DATA_CHUNKS, 16'd0);
    send_byte(8'hC3);
    write_reg(crs_pkg::REG_DATA_CHUNKS, 16'hFFE1);
    send_byte(8'h3C);
    write_reg(crs_pkg::REG_DATA_CHUNKS, 16'd2);
    write_reg(crs_pkg::REG_PARITY_CHUNKS, 16'd0);
    send_byte(8'h11);
    write_reg(crs_pkg::REG_PARITY_CHUNKS, 16'd17);
    send_byte(8'hEE);
    write_reg(crs_pkg::REG_PARITY_CHUNKS, 16'd2);
    write_reg(crs_pkg::REG_CHUNK_LEN, 16'd0);
    send_byte(8'h5A);
    write_reg(crs_pkg::REG_CHUNK_LEN, 16'd257);
    send_byte(8'hA5);
    bad_layouts += 6;
    write_reg(crs_pkg::REG_CHUNK_LEN, 16'd1);
    send_byte(8'h96);
    send_byte(8'h69);

    // longest chunk, all rows; receiver holds off at the start
    set_layout(1, 16, crs_pkg::MAX_CHUNK_LEN);
    hold_req = 1'b1;
    send_random(crs_pkg::MAX_CHUNK_LEN);

    // most data chunks, two blocks, no idling on either side
    no_idle = 1'b1;
    set_layout(crs_pkg::MAX_DATA_CHUNKS, 16, 1);
    send_random(2 * crs_pkg::MAX_DATA_CHUNKS);
    no_idle = 1'b0;

    // random layouts: mostly whole blocks, some cut short or bad
    while (rand_bytes < RAND_TARGET) begin
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0: begin
            bad_val = ($urandom_range(1) != 0) ? $urandom_range(33, 63) : 0;
            write_reg(crs_pkg::REG_DATA_CHUNKS, {10'($urandom), 6'(bad_val)});
          end
          1: begin
            bad_val = ($urandom_range(1) != 0) ? $urandom_range(17, 31) : 0;
            write_reg(crs_pkg::REG_PARITY_CHUNKS, {11'($urandom), 5'(bad_val)});
          end
          default: begin
            bad_val = ($urandom_range(1) != 0) ? $urandom_range(257, 511) : 0;
            write_reg(crs_pkg::REG_CHUNK_LEN, {7'($urandom), 9'(bad_val)});
          end
        endcase
        bad_layouts++;
        send_random($urandom_range(1, 3));
      end else begin
        k   = ($urandom_range(9) == 0) ? crs_pkg::MAX_DATA_CHUNKS : $urandom_range(1, 5);
        r   = $urandom_range(1, 16);
        len = (k == crs_pkg::MAX_DATA_CHUNKS) ? 1 : $urandom_range(1, 6);
        set_layout(k, r, len);
        total = k * len * $urandom_range(1, 2);
        if ($urandom_range(9) == 0) begin
          total = $urandom_range(1, total);
        end
        if ($urandom_range(5) == 0) begin
          cut = $urandom_range(0, total);
          send_random(cut);
          write_reg(crs_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                    16'($urandom));
          send_random(total - cut);
        end else begin
          send_random(total);
        end
      end
    end

    quiesce();
    ledger.close_out();
    $display("covered %0d data bytes, %0d parity results checked, %0d register writes",
             ledger.bytes_seen, ledger.checked, reg_writes);
    $display("layouts 1..32 chunks, 1..16 rows, 1..256 bytes, %0d bad ones, %0d-cycle hold-off",
             bad_layouts, HOLD_CYCLES);
    if (ledger.errors == 0) begin
      $display("tb_cauchy_rs_erasure_encoder_core: clean");
    end else begin
      $display("tb_cauchy_rs_erasure_encoder_core: errors");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/crs_pkg.sv
hdl/crs_ctrl.sv
hdl/crs_datapath.sv
hdl/cauchy_rs_erasure_encoder_core.sv
tb/sv/tb_cauchy_rs_erasure_encoder_core.sv
